FILE: hw/rtl/ptc_pkg.sv
// Package for the perceptron train/classify block.
// Holds field widths, register indexes, controller states and the
// command and status structs shared by controller, datapath and top level.
package ptc_pkg;

	localparam int MAX_DIM_DEF = 64;

	localparam int LEN_W      = 7;
	localparam int THR_W      = 16;
	localparam int ELEM_W     = 16;
	localparam int WEIGHT_W   = 32;
	localparam int ACC_W      = 48;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DECISION_THRESHOLD = 1'd1;

	localparam logic [LEN_W-1:0] LEN_RESET = 7'd2;
	localparam logic [THR_W-1:0] THR_RESET = 16'd0;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_DECIDE,
		ST_WALK,
		ST_WLAST,
		ST_OUT
	} ptc_state_t;

	typedef struct packed {
		logic clear_en;
		logic accept;
		logic mul;
		logic acc;
		logic decide;
		logic walk_rd;
		logic load_out;
	} ptc_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic last;
		logic upd;
		logic walk_last;
		logic out_free;
	} ptc_sts_t;

endpackage

FILE: hw/rtl/ptc_ctrl.sv
// Controller state machine of the perceptron block.
// Sequences clear, multiply-accumulate, decision and weight update walk.
// Depends on ptc_pkg.
module ptc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  ptc_pkg::ptc_sts_t sts,
	output ptc_pkg::ptc_cmd_t cmd
);
	import ptc_pkg::*;

	ptc_state_t state_q;
	ptc_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_en = 1'b1;
				if (sts.clear_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = sts.last ? ST_DECIDE : ST_IDLE;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = sts.upd ? ST_WALK : ST_OUT;
			end
			ST_WALK: begin
				cmd.walk_rd = 1'b1;
				if (sts.walk_last) begin
					state_d = ST_WLAST;
				end
			end
			ST_WLAST: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// An accepted item always moves on to the multiply step.
	a_accept_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (state_q == ST_MUL))
		else $error("accepted item did not enter the multiply step");

	// A result is never loaded over one that is still waiting.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.out_free)
		else $error("result loaded while output register busy");

	// Items are only taken while the controller is idle.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (state_q == ST_IDLE))
		else $error("input ready outside the idle state");

endmodule

FILE: hw/rtl/ptc_dp.sv
// Datapath of the perceptron block: configuration registers, weight and
// vector memories, multiplier, saturating accumulator, update walk and
// output register. Depends on ptc_pkg.
module ptc_dp #(
	parameter int MAX_DIM = ptc_pkg::MAX_DIM_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ptc_pkg::ptc_cmd_t                   cmd,
	output ptc_pkg::ptc_sts_t                   sts,
	input  logic                                cfg_we,
	input  logic [ptc_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [ptc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic signed [ptc_pkg::ELEM_W-1:0]   in_elem,
	input  logic                                in_mode,
	input  logic                                in_label,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                out_pred,
	output logic                                out_upd,
	output logic                                out_train
);
	import ptc_pkg::*;

	localparam int IDX_W = $clog2(MAX_DIM);
	localparam int CNT_W = IDX_W + 1;
	localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
	localparam logic [CMP_W-1:0] MAX_EXT = CMP_W'(MAX_DIM);
	localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(MAX_DIM - 1);
	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic signed [WEIGHT_W-1:0] W_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
	localparam logic signed [WEIGHT_W-1:0] W_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

	logic [LEN_W-1:0] len_q;
	logic [THR_W-1:0] thr_q;
	logic [IDX_W-1:0] count_q;
	logic [CNT_W-1:0] taken_q;
	logic             last_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] prod_q;
	logic signed [ELEM_W-1:0] x_q;
	logic             mode_q;
	logic             label_q;
	logic             pred_q;
	logic             upd_q;
	logic [IDX_W-1:0] clr_addr_q;
	logic [IDX_W-1:0] walk_q;
	logic             wr_pend_q;
	logic [IDX_W-1:0] wr_addr_s1;
	logic signed [WEIGHT_W-1:0] w_rd_q;
	logic signed [ELEM_W-1:0]   v_rd_q;
	logic             out_valid_q;
	logic             out_pred_q;
	logic             out_upd_q;
	logic             out_train_q;

	logic signed [WEIGHT_W-1:0] wmem [MAX_DIM];
	logic signed [ELEM_W-1:0]   vmem [MAX_DIM];

	logic [CMP_W-1:0] len_ext;
	logic [CMP_W-1:0] len_clamp;
	logic [CNT_W-1:0] eff_len;
	logic [CNT_W-1:0] taken_next;
	logic [IDX_W-1:0] rd_addr;
	logic signed [ACC_W:0]      acc_sum;
	logic signed [ACC_W-1:0]    acc_sat;
	logic signed [WEIGHT_W:0]   delta;
	logic signed [WEIGHT_W:0]   w_sum;
	logic signed [WEIGHT_W-1:0] w_new;
	logic             pred;
	logic             upd;

	always_comb begin
		len_ext = CMP_W'(len_q);
		if (len_ext == '0) begin
			len_clamp = CMP_W'(1);
		end else if (len_ext > MAX_EXT) begin
			len_clamp = MAX_EXT;
		end else begin
			len_clamp = len_ext;
		end
		eff_len    = CNT_W'(len_clamp);
		taken_next = {1'b0, count_q} + CNT_W'(1);
		rd_addr    = cmd.walk_rd ? walk_q : count_q;

		acc_sum = {acc_q[ACC_W-1], acc_q} + {prod_q[ACC_W-1], prod_q};
		if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
			acc_sat = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
		end else begin
			acc_sat = acc_sum[ACC_W-1:0];
		end

		delta = (WEIGHT_W+1)'(v_rd_q);
		if (!label_q) begin
			delta = -delta;
		end
		w_sum = {w_rd_q[WEIGHT_W-1], w_rd_q} + delta;
		if (w_sum[WEIGHT_W] != w_sum[WEIGHT_W-1]) begin
			w_new = w_sum[WEIGHT_W] ? W_MIN : W_MAX;
		end else begin
			w_new = w_sum[WEIGHT_W-1:0];
		end

		pred = acc_q > $signed({{(ACC_W-THR_W){1'b0}}, thr_q});
		upd  = !mode_q && (pred != label_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= LEN_RESET;
			thr_q       <= THR_RESET;
			count_q     <= '0;
			taken_q     <= '0;
			last_q      <= 1'b0;
			acc_q       <= '0;
			pred_q      <= 1'b0;
			upd_q       <= 1'b0;
			clr_addr_q  <= '0;
			walk_q      <= '0;
			wr_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_VECTOR_LENGTH:      len_q <= cfg_wdata[LEN_W-1:0];
					REG_DECISION_THRESHOLD: thr_q <= cfg_wdata[THR_W-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.clear_en) begin
				clr_addr_q <= clr_addr_q + IDX_W'(1);
			end
			if (cmd.accept) begin
				taken_q <= taken_next;
				if (taken_next >= eff_len) begin
					last_q  <= 1'b1;
					count_q <= '0;
				end else begin
					last_q  <= 1'b0;
					count_q <= count_q + IDX_W'(1);
				end
			end
			if (cmd.acc) begin
				acc_q <= acc_sat;
			end
			if (cmd.decide) begin
				pred_q <= pred;
				upd_q  <= upd;
				acc_q  <= '0;
				walk_q <= '0;
			end
			if (cmd.walk_rd) begin
				walk_q <= walk_q + IDX_W'(1);
			end
			wr_pend_q <= cmd.walk_rd;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_q     <= in_elem;
			mode_q  <= in_mode;
			label_q <= in_label;
		end
		if (cmd.mul) begin
			prod_q <= w_rd_q * x_q;
		end
		wr_addr_s1 <= walk_q;
		if (cmd.load_out) begin
			out_pred_q  <= pred_q;
			out_upd_q   <= upd_q;
			out_train_q <= !mode_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_en) begin
			wmem[clr_addr_q] <= '0;
		end else if (wr_pend_q) begin
			wmem[wr_addr_s1] <= w_new;
		end
		if (cmd.accept || cmd.walk_rd) begin
			w_rd_q <= wmem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			vmem[count_q] <= in_elem;
		end
		if (cmd.walk_rd) begin
			v_rd_q <= vmem[walk_q];
		end
	end

	assign sts.clear_done = (clr_addr_q == LAST_ADDR);
	assign sts.last       = last_q;
	assign sts.upd        = upd;
	assign sts.walk_last  = ({1'b0, walk_q} == (taken_q - CNT_W'(1)));
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_pred  = out_pred_q;
	assign out_upd   = out_upd_q;
	assign out_train = out_train_q;

	// The update walk only runs after a training mispredict.
	a_walk_on_upd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_rd |-> upd_q)
		else $error("weight walk without a mispredict");

	// No new element is taken while a weight write is still pending.
	a_no_accept_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_pend_q |-> !cmd.accept)
		else $error("item accepted during weight write");

	// Only a training vector can report a weight update.
	a_upd_training: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_upd_q) |-> out_train_q)
		else $error("weight update reported for a classify vector");

endmodule

FILE: hw/rtl/perceptron_train_classify.sv
// Top level of the perceptron train/classify block.
// Joins the controller ptc_ctrl and the datapath ptc_dp. Depends on ptc_pkg.
//
// One item carries one signed Q8.8 vector element; after the element that
// completes a vector, one result item reports the predicted class. Each
// element passes through a weight memory read, a 32x16 multiply and a
// saturating 48-bit accumulate. A completed vector then adds a decision
// and a result load, and a training mispredict adds an update walk over
// the buffered elements, one weight memory read and write per cycle.
// The result load waits for as long as an earlier result is still held by
// a stalled output, and no item is taken meanwhile.
// While the weight memory is cleared after reset no item is accepted;
// configuration writes are taken at any time.
module perceptron_train_classify #(
	parameter int MAX_DIM = ptc_pkg::MAX_DIM_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ptc_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [ptc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [15:0]                        s_axis_tdata,  // element_value
	input  logic [1:0]                         s_axis_tuser,  // mode, label_positive
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [7:0]                         m_axis_tdata,  // predicted_positive, weights_updated, zeros
	output logic                               m_axis_tuser   // from_training
);
	import ptc_pkg::*;

	ptc_cmd_t cmd;
	ptc_sts_t sts;
	logic     out_pred;
	logic     out_upd;

	ptc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ptc_dp #(
		.MAX_DIM (MAX_DIM)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_elem   ($signed(s_axis_tdata)),
		.in_mode   (s_axis_tuser[0]),
		.in_label  (s_axis_tuser[1]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_pred  (out_pred),
		.out_upd   (out_upd),
		.out_train (m_axis_tuser)
	);

	assign m_axis_tdata = {6'd0, out_upd, out_pred};

endmodule

FILE: verif/perceptron_train_classify_checker.sv
// Checker for the perceptron train/classify block: watches the config port and both
// item channels, predicts each class result and compares it with the block's output.
// Depends on ptc_pkg for widths, reset values and register indexes.
module perceptron_train_classify_checker #(
	parameter int MAX_DIM = ptc_pkg::MAX_DIM_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ptc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [ptc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [15:0]                    s_axis_tdata,  // element_value
	input  logic [1:0]                     s_axis_tuser,  // mode, label_positive
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [7:0]                     m_axis_tdata,  // predicted_positive, weights_updated
	input  logic                           m_axis_tuser,  // from_training
	output int                             mismatches,
	output int                             pending
);
	import ptc_pkg::*;

	typedef struct packed {
		logic predicted_positive;
		logic weights_updated;
		logic from_training;
	} class_result_t;

	localparam longint ACC_HI = (longint'(1) <<< (ACC_W - 1)) - 1;
	localparam longint ACC_LO = -(longint'(1) <<< (ACC_W - 1));
	localparam longint WGT_HI = (longint'(1) <<< (WEIGHT_W - 1)) - 1;
	localparam longint WGT_LO = -(longint'(1) <<< (WEIGHT_W - 1));

	logic [LEN_W-1:0]           len_reg;
	logic [THR_W-1:0]           thr_reg;
	logic signed [WEIGHT_W-1:0] weights [MAX_DIM];
	logic signed [ELEM_W-1:0]   elements [MAX_DIM];
	int                         taken_count;
	longint                     dot_sum;
	int                         bad;
	class_result_t              class_q [$];

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	task automatic absorb_element(input logic classify, input logic signed [ELEM_W-1:0] x,
		input logic label_pos);
		int     idx;
		int     len;
		int     taken;
		logic   pred;
		logic   upd;
		longint w;
		idx = (taken_count >= MAX_DIM) ? MAX_DIM - 1 : taken_count;
		len = int'(len_reg);
		if (len < 1)
			len = 1;
		if (len > MAX_DIM)
			len = MAX_DIM;
		elements[idx] = x;
		dot_sum = clamp(dot_sum + longint'(weights[idx]) * longint'(x), ACC_LO, ACC_HI);
		taken = idx + 1;
		if (taken < len) begin
			taken_count = taken;
		end else begin
			pred = dot_sum > longint'(thr_reg);
			upd = !classify && (pred != label_pos);
			if (upd) begin
				for (int i = 0; i < taken; i++) begin
					w = longint'(weights[i]) +
						(label_pos ? longint'(elements[i]) : -longint'(elements[i]));
					weights[i] = WEIGHT_W'(clamp(w, WGT_LO, WGT_HI));
				end
			end
			class_q.push_back('{pred, upd, !classify});
			taken_count = 0;
			dot_sum = 0;
		end
	endtask

	task automatic check_result(input class_result_t got);
		class_result_t want;
		if (class_q.size() == 0) begin
			bad++;
			if (bad <= 10)
				$display("Unexpected result item: predicted_positive=%0b weights_updated=%0b from_training=%0b",
					got.predicted_positive, got.weights_updated, got.from_training);
		end else begin
			want = class_q.pop_front();
			if (got !== want) begin
				bad++;
				if (bad <= 10)
					$display("Result mismatch: expected pred=%0b upd=%0b train=%0b, actual pred=%0b upd=%0b train=%0b",
						want.predicted_positive, want.weights_updated, want.from_training,
						got.predicted_positive, got.weights_updated, got.from_training);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_reg = LEN_RESET;
			thr_reg = THR_RESET;
			for (int i = 0; i < MAX_DIM; i++)
				weights[i] = '0;
			taken_count = 0;
			dot_sum = 0;
			bad = 0;
			class_q.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_idx == REG_VECTOR_LENGTH)
					len_reg = cfg_wdata[LEN_W-1:0];
				else if (cfg_idx == REG_DECISION_THRESHOLD)
					thr_reg = cfg_wdata[THR_W-1:0];
			end
			if (m_axis_tvalid && m_axis_tready)
				check_result('{m_axis_tdata[0], m_axis_tdata[1], m_axis_tuser});
			if (s_axis_tvalid && s_axis_tready)
				absorb_element(s_axis_tuser[0], s_axis_tdata, s_axis_tuser[1]);
		end
		mismatches <= bad;
		pending <= class_q.size();
	end

endmodule

FILE: verif/perceptron_train_classify_tb.sv
// Testbench top for the perceptron train/classify block: drives reset, register
// writes and element items with random idling, and gives the verdict.
// Depends on ptc_pkg, the block and perceptron_train_classify_checker.
module perceptron_train_classify_tb;
	import ptc_pkg::*;

	localparam int MAX_DIM = MAX_DIM_DEF;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [15:0]           s_axis_tdata;  // element_value
	logic [1:0]            s_axis_tuser;  // mode, label_positive
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [7:0]            m_axis_tdata;  // predicted_positive, weights_updated
	logic                  m_axis_tuser;  // from_training
	int                    mismatches;
	int                    pending;
	bit                    steady;
	int                    sent;

	perceptron_train_classify #(.MAX_DIM(MAX_DIM)) u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	perceptron_train_classify_checker #(.MAX_DIM(MAX_DIM)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.mismatches(mismatches), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_element(input logic classify, input logic [15:0] value,
		input logic label_pos);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 6);
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= value;
		s_axis_tuser <= {label_pos, classify};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sent++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_element();
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'($urandom_range(0, 511) - 256);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [LEN_W-1:0] pick_length();
		case ($urandom_range(0, 9))
			0: return 7'd1;
			1: return 7'd64;
			2: return 7'd0;
			3: return 7'($urandom_range(65, 127));
			4: return 7'($urandom_range(2, 64));
			default: return 7'($urandom_range(1, 8));
		endcase
	endfunction

	function automatic logic [THR_W-1:0] pick_threshold();
		case ($urandom_range(0, 3))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 255));
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		m_axis_tready = 1'b0;
		wait (arst_n);
		forever begin
			int stall;
			stall = steady ? 0 : $urandom_range(0, 6);
			@(negedge clk);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do
				@(posedge clk);
			while (!m_axis_tvalid);
		end
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		steady = 1'b0;
		sent = 0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// Reset length of two and zero weights: classify, then train on a miss.
		send_element(1'b1, 16'h7FFF, 1'b0);
		send_element(1'b1, 16'h8000, 1'b1);
		send_element(1'b1, 16'h7FFF, 1'b1);
		send_element(1'b0, 16'h8000, 1'b1);
		send_element(1'b0, 16'h7FFF, 1'b0);
		send_element(1'b1, 16'h8000, 1'b0);
		send_element(1'b1, 16'h7FFF, 1'b1);
		send_element(1'b0, 16'h8000, 1'b0);
		drain_results();

		write_reg(REG_VECTOR_LENGTH, 16'd1);
		write_reg(REG_DECISION_THRESHOLD, 16'hFFFF);
		send_element(1'b0, 16'h7FFF, 1'b1);
		send_element(1'b0, 16'h7FFF, 1'b1);
		send_element(1'b0, 16'h0001, 1'b1);
		send_element(1'b0, 16'h8000, 1'b0);
		drain_results();

		write_reg(REG_VECTOR_LENGTH, 16'd0);
		write_reg(REG_DECISION_THRESHOLD, 16'd0);
		send_element(1'b1, 16'h8000, 1'b0);
		send_element(1'b0, 16'h0100, 1'b1);
		drain_results();

		// Shrinking the length under a partly taken vector completes it with the next element.
		write_reg(REG_VECTOR_LENGTH, 16'd127);
		send_element(1'b0, 16'h7FFF, 1'b0);
		send_element(1'b0, 16'h8000, 1'b1);
		send_element(1'b1, 16'h1234, 1'b0);
		drain_results();
		write_reg(REG_VECTOR_LENGTH, 16'd2);
		send_element(1'b0, 16'hFFFF, 1'b1);
		drain_results();

		while (sent < 1825) begin
			int phase_items;
			steady = ($urandom_range(0, 3) == 0);
			write_reg(REG_VECTOR_LENGTH, {9'($urandom), pick_length()});
			if ($urandom_range(0, 2) != 0)
				write_reg(REG_DECISION_THRESHOLD, pick_threshold());
			phase_items = $urandom_range(10, 80);
			repeat (phase_items)
				send_element(1'($urandom), pick_element(), 1'($urandom));
			drain_results();
		end

		steady = 1'b0;
		drain_results();
		repeat (80) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
